// ===== design/sfp_pkg.sv =====
// sfp_pkg: shared types and constants for the sensor frame packer
// no dependencies; the design modules refer to it by scoped names

package sfp_pkg;

  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SPF_W    = 9;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned JOB_W    = 48;
  localparam int unsigned NBYTES_W = 3;

  localparam logic [SPF_W-1:0] SPF_RESET = 9'd16;

  // byte counts of the three kinds of burst
  localparam logic [NBYTES_W-1:0] NB_STAMP  = 3'd6;
  localparam logic [NBYTES_W-1:0] NB_SAMPLE = 3'd2;
  localparam logic [NBYTES_W-1:0] NB_CLOSE  = 3'd4;

  typedef enum logic {
    ACT_FRAME_START = 1'b0,
    ACT_SAMPLE      = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    REG_TIMESTAMP_EN = 2'd0,
    REG_CHECKSUM_EN  = 2'd1,
    REG_SAMPLES      = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic             timestamp_enable;
    logic             checksum_enable;
    logic [SPF_W-1:0] samples_per_frame;
  } sfp_cfg_t;

  // one burst of bytes for the serializer, sent msb first
  typedef struct packed {
    logic [JOB_W-1:0]    data;
    logic [NBYTES_W-1:0] nbytes;
    logic                last;
  } sfp_job_t;

endpackage

// ===== design/sfp_in_if.sv =====
// sfp_in_if: input channel of the sensor frame packer, valid/ready with payload
// depends on nothing

interface sfp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] epoch_seconds;
  logic [9:0]  milliseconds;
  logic [15:0] sample_mv;

  modport source (output valid, action, epoch_seconds, milliseconds, sample_mv,
                  input ready);
  modport sink (input valid, action, epoch_seconds, milliseconds, sample_mv,
                output ready);
endinterface

// ===== design/sfp_out_if.sv =====
// sfp_out_if: result channel of the sensor frame packer, one frame byte a beat
// depends on nothing

interface sfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, frame_byte, frame_last, input ready);
  modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

// ===== design/sensor_frame_packer.sv =====
// sensor_frame_packer: packs sensor readings and timestamps into a byte frame
// depends on sfp_pkg, sfp_in_if, sfp_out_if, sfp_regs, sfp_front, sfp_queue,
// sfp_back
//
// in_bus takes one item a beat: a frame start (action 0) clears the sample
// count and sum and, with timestamps on, queues six timestamp bytes; a sample
// (action 1) queues its two bytes, plus two sum bytes when it closes a frame
// with checksums on. out_bus carries one frame byte a beat, frame_last on the
// closing byte. The apb port writes the three registers at 0x0, 0x4 and 0x8.
// An accepted item is written into the queue and then loaded into the serializer
// register before its first byte goes out. Output runs at one byte per cycle
// while out_bus.ready holds and bursts are waiting; the serializer sets this pace.
// A two-entry queue sits between the front and the serializer, so the input
// keeps taking items while a byte waits on a stalled receiver; once the queue
// is full in_bus.ready drops until the serializer takes the next burst.
// Synchronous reset empties the queue and serializer, clears count and sum,
// and restores registers to timestamps off, checksum off, 16 samples.

module sensor_frame_packer #(
  parameter int unsigned MAX_SAMPLES = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  sfp_in_if.sink                     in_bus,
  sfp_out_if.source                  out_bus,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfp_pkg::ADDR_W-1:0] paddr,
  input  logic [sfp_pkg::DATA_W-1:0] pwdata,
  output logic [sfp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  sfp_pkg::sfp_cfg_t cfg;
  sfp_pkg::sfp_job_t push_job, pop_job;
  logic              push_valid, push_ready;
  logic              pop_valid, pop_ready;

  sfp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfp_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_bus    (in_bus),
    .job_ready (push_ready),
    .job_valid (push_valid),
    .job       (push_job)
  );

  sfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  sfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .out_bus   (out_bus)
  );

endmodule

// ===== design/sfp_regs.sv =====
// sfp_regs: apb-style configuration registers of the frame packer
// depends on sfp_pkg

module sfp_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfp_pkg::ADDR_W-1:0] paddr,
  input  logic [sfp_pkg::DATA_W-1:0] pwdata,
  output logic [sfp_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output sfp_pkg::sfp_cfg_t          cfg
);

  sfp_pkg::sfp_cfg_t cfg_r;
  sfp_pkg::sfp_cfg_t cfg_nxt;
  sfp_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = sfp_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        sfp_pkg::REG_TIMESTAMP_EN: cfg_nxt.timestamp_enable = pwdata[0];
        sfp_pkg::REG_CHECKSUM_EN:  cfg_nxt.checksum_enable = pwdata[0];
        sfp_pkg::REG_SAMPLES:      cfg_nxt.samples_per_frame = pwdata[sfp_pkg::SPF_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sfp_pkg::REG_TIMESTAMP_EN: prdata = {31'd0, cfg_r.timestamp_enable};
      sfp_pkg::REG_CHECKSUM_EN:  prdata = {31'd0, cfg_r.checksum_enable};
      sfp_pkg::REG_SAMPLES:      prdata = {23'd0, cfg_r.samples_per_frame};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timestamp_enable  <= 1'b0;
      cfg_r.checksum_enable   <= 1'b0;
      cfg_r.samples_per_frame <= sfp_pkg::SPF_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/sfp_front.sv =====
// sfp_front: accepts beats, keeps the frame count and checksum and turns samples
// and timestamped frame starts into queue bursts; depends on sfp_pkg, sfp_in_if

module sfp_front #(
  parameter int unsigned MAX_SAMPLES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sfp_pkg::sfp_cfg_t cfg,
  sfp_in_if.sink            in_bus,
  input  logic              job_ready,
  output logic              job_valid,
  output sfp_pkg::sfp_job_t job
);

  localparam logic [sfp_pkg::LEN_W-1:0] MaxLen = sfp_pkg::LEN_W'(MAX_SAMPLES);

  logic [sfp_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [sfp_pkg::SPF_W-1:0] seen_r, seen_nxt;
  logic [sfp_pkg::SPF_W-1:0] seen_inc;
  logic [sfp_pkg::SUM_W-1:0] sum_add;
  logic [sfp_pkg::LEN_W-1:0] spf_ext, frame_len;
  logic                      done;
  logic                      accept;
  sfp_pkg::action_t          act;

  assign act          = sfp_pkg::action_t'(in_bus.action);
  assign in_bus.ready = job_ready;
  assign accept       = in_bus.valid & job_ready;

  // zero counts as one, anything above the limit is clipped
  always_comb begin
    spf_ext = sfp_pkg::LEN_W'(cfg.samples_per_frame);
    if (spf_ext == '0) begin
      frame_len = sfp_pkg::LEN_W'(1);
    end else if (spf_ext > MaxLen) begin
      frame_len = MaxLen;
    end else begin
      frame_len = spf_ext;
    end
  end

  assign seen_inc = seen_r + 1'b1;
  assign sum_add  = cfg.checksum_enable ? sum_r + in_bus.sample_mv : sum_r;
  assign done     = sfp_pkg::LEN_W'(seen_inc) >= frame_len;

  always_comb begin
    sum_nxt    = sum_r;
    seen_nxt   = seen_r;
    job_valid  = 1'b0;
    job.data   = {in_bus.sample_mv, 32'd0};
    job.nbytes = sfp_pkg::NB_SAMPLE;
    job.last   = done;
    unique case (act)
      sfp_pkg::ACT_FRAME_START: begin
        job.data   = {in_bus.epoch_seconds, 6'd0, in_bus.milliseconds};
        job.nbytes = sfp_pkg::NB_STAMP;
        job.last   = 1'b0;
        job_valid  = in_bus.valid & cfg.timestamp_enable;
        if (accept) begin
          sum_nxt  = '0;
          seen_nxt = '0;
        end
      end
      sfp_pkg::ACT_SAMPLE: begin
        job_valid = in_bus.valid;
        if (done && cfg.checksum_enable) begin
          job.data   = {in_bus.sample_mv, sum_add, 16'd0};
          job.nbytes = sfp_pkg::NB_CLOSE;
        end
        if (accept) begin
          sum_nxt  = done ? '0 : sum_add;
          seen_nxt = done ? '0 : seen_inc;
        end
      end
      default: job_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      seen_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// ===== design/sfp_queue.sv =====
// sfp_queue: two-entry job queue between the front and the serializer
// depends on sfp_pkg

module sfp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  sfp_pkg::sfp_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output sfp_pkg::sfp_job_t pop_job
);

  sfp_pkg::sfp_job_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_job    = mem[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== design/sfp_back.sv =====
// sfp_back: byte serializer, shifts each job out msb first on the result channel
// depends on sfp_pkg, sfp_out_if

module sfp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  sfp_pkg::sfp_job_t job,
  sfp_out_if.source         out_bus
);

  logic [sfp_pkg::JOB_W-1:0]    data_r, data_nxt;
  logic [sfp_pkg::NBYTES_W-1:0] rem_r, rem_nxt;
  logic                         last_r, last_nxt;
  logic                         beat;

  assign out_bus.valid      = rem_r != '0;
  assign out_bus.frame_byte = data_r[sfp_pkg::JOB_W-1 -: 8];
  assign out_bus.frame_last = last_r & (rem_r == sfp_pkg::NBYTES_W'(1));
  assign beat               = out_bus.valid & out_bus.ready;

  // reload when idle or as the final byte of the current burst goes out
  assign job_ready = (rem_r == '0) | (beat & (rem_r == sfp_pkg::NBYTES_W'(1)));

  always_comb begin
    data_nxt = data_r;
    rem_nxt  = rem_r;
    last_nxt = last_r;
    if (beat) begin
      data_nxt = {data_r[sfp_pkg::JOB_W-9:0], 8'd0};
      rem_nxt  = rem_r - 1'b1;
    end
    if (job_ready && job_valid) begin
      data_nxt = job.data;
      rem_nxt  = job.nbytes;
      last_nxt = job.last;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== verif/sensor_frame_packer_tb.sv =====
// sensor_frame_packer_tb: self-checking bench for the sensor frame packer
// drives items and apb writes, predicts every frame byte and checks it in order
// depends on sfp_pkg, sfp_in_if, sfp_out_if and sensor_frame_packer
`timescale 1ns / 100ps

module sensor_frame_packer_tb;

  localparam int unsigned MAX_SAMPLES   = 256;
  localparam int unsigned SETTLE_CYCLES = 10;

  // expected byte stream of the packer, built from accepted items
  class frame_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       last;
    } frame_beat_t;

    bit              ts_en;
    bit              cs_en;
    logic [8:0]      spf;
    logic [15:0]     running_sum;
    logic [8:0]      samples_seen;
    int unsigned     max_len;
    int unsigned     errors;
    frame_beat_t     expected_beats[$];

    function new(int unsigned max_samples);
      max_len      = max_samples;
      ts_en        = 1'b0;
      cs_en        = 1'b0;
      spf          = sfp_pkg::SPF_RESET;
      running_sum  = '0;
      samples_seen = '0;
      errors       = 0;
    endfunction

    function int unsigned frame_len();
      if (spf == 0) return 1;
      if (spf > max_len) return max_len;
      return spf;
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    function void write_reg(sfp_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        sfp_pkg::REG_TIMESTAMP_EN: ts_en = value[0];
        sfp_pkg::REG_CHECKSUM_EN:  cs_en = value[0];
        sfp_pkg::REG_SAMPLES:      spf = value[8:0];
        default: ;
      endcase
    endfunction

    function void push_beat(logic [7:0] data, logic last);
      frame_beat_t beat;
      beat.data = data;
      beat.last = last;
      expected_beats.push_back(beat);
    endfunction

    function void note_item(sfp_pkg::action_t act, logic [31:0] secs, logic [9:0] ms,
                            logic [15:0] mv);
      bit done;
      if (act == sfp_pkg::ACT_FRAME_START) begin
        running_sum  = '0;
        samples_seen = '0;
        if (ts_en) begin
          push_beat(secs[31:24], 1'b0);
          push_beat(secs[23:16], 1'b0);
          push_beat(secs[15:8], 1'b0);
          push_beat(secs[7:0], 1'b0);
          push_beat({6'd0, ms[9:8]}, 1'b0);
          push_beat(ms[7:0], 1'b0);
        end
        return;
      end
      if (cs_en) running_sum = running_sum + mv;
      samples_seen = samples_seen + 9'd1;
      done = (samples_seen >= frame_len());
      push_beat(mv[15:8], 1'b0);
      if (done && cs_en) begin
        push_beat(mv[7:0], 1'b0);
        push_beat(running_sum[15:8], 1'b0);
        push_beat(running_sum[7:0], 1'b1);
      end else begin
        push_beat(mv[7:0], done);
      end
      if (done) begin
        running_sum  = '0;
        samples_seen = '0;
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      frame_beat_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none, got byte %02h last %0b",
                 $time, data, last);
        return;
      end
      want = expected_beats.pop_front();
      if (data !== want.data) begin
        errors++;
        $display("%0t: frame_byte mismatch: expected %02h, got %02h",
                 $time, want.data, data);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: frame_last mismatch: expected %0b, got %0b",
                 $time, want.last, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [sfp_pkg::ADDR_W-1:0]   paddr;
  logic [sfp_pkg::DATA_W-1:0]   pwdata;
  logic [sfp_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  sfp_in_if  in_if ();
  sfp_out_if out_if ();

  frame_scoreboard sb;
  bit              quiet;
  bit              hold_req;
  int unsigned     hold_len;

  sensor_frame_packer #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_byte(out_if.frame_byte, out_if.frame_last);
  end

  initial begin : result_sink
    int unsigned low_left;
    low_left = 0;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off, counted here while the sender keeps pushing
        out_if.ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (low_left != 0) begin
        out_if.ready <= 1'b0;
        low_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 2) == 0) low_left = pick_gap();
      end
    end
  end

  initial begin
    #5_000_000;
    $display("sensor_frame_packer_tb: FAIL");
    $finish;
  end

  task automatic apb_write(sfp_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(sfp_pkg::action_t act, logic [31:0] secs, logic [9:0] ms,
                           logic [15:0] mv);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.action        <= act;
    in_if.epoch_seconds <= secs;
    in_if.milliseconds  <= ms;
    in_if.sample_mv     <= mv;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_item(act, secs, ms, mv);
  endtask

  task automatic send_random(sfp_pkg::action_t act);
    logic [9:0]  ms;
    logic [15:0] mv;
    if (act == sfp_pkg::ACT_FRAME_START)
      ms = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(1000, 1023))
                                       : 10'($urandom_range(0, 999));
    else
      ms = 10'($urandom_range(0, 1023));
    case ($urandom_range(0, 15))
      0:       mv = 16'h0000;
      1:       mv = 16'hffff;
      default: mv = 16'($urandom_range(0, 65535));
    endcase
    send_item(act, $urandom, ms, mv);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic configure(bit ts, bit cs, logic [8:0] spf);
    wait_for_drain();
    // a frame start with timestamps off leaves nothing to wait for
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(sfp_pkg::REG_TIMESTAMP_EN, {31'd0, ts});
    apb_write(sfp_pkg::REG_CHECKSUM_EN, {31'd0, cs});
    apb_write(sfp_pkg::REG_SAMPLES, {23'd0, spf});
  endtask

  // mostly whole frames with random content, some stray items in between
  task automatic run_items(int unsigned budget);
    int unsigned sent;
    int unsigned flen;
    int unsigned k;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 4) != 0) begin
        flen = sb.frame_len();
        send_random(sfp_pkg::ACT_FRAME_START);
        sent++;
        for (k = 0; k < flen && sent < budget; k++) begin
          send_random(sfp_pkg::ACT_SAMPLE);
          sent++;
        end
      end else begin
        send_random($urandom_range(0, 1) ? sfp_pkg::ACT_SAMPLE : sfp_pkg::ACT_FRAME_START);
        sent++;
      end
    end
  endtask

  task automatic run_phase(logic [8:0] spf, int unsigned budget);
    configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), spf);
    quiet = ($urandom_range(0, 3) == 0);
    run_items(budget);
  endtask

  initial begin
    logic [8:0] spf_list[8];
    sb       = new(MAX_SAMPLES);
    quiet    = 1'b0;
    hold_req = 1'b0;
    hold_len = 0;
    rst_n    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_if.valid         = 1'b0;
    in_if.action        = sfp_pkg::ACT_FRAME_START;
    in_if.epoch_seconds = '0;
    in_if.milliseconds  = '0;
    in_if.sample_mv     = '0;
    spf_list = '{9'd1, 9'd256, 9'd3, 9'd0, 9'd2, 9'd300, 9'd7, 9'd5};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // field extremes, sum wrap, milliseconds above 999
    configure(1'b1, 1'b1, 9'd2);
    send_item(sfp_pkg::ACT_FRAME_START, 32'hffff_ffff, 10'd999, 16'h0000);
    send_item(sfp_pkg::ACT_SAMPLE, 32'h0, 10'd0, 16'hffff);
    send_item(sfp_pkg::ACT_SAMPLE, 32'h0, 10'd0, 16'hffff);
    send_item(sfp_pkg::ACT_FRAME_START, 32'h0000_0000, 10'd0, 16'hffff);
    send_item(sfp_pkg::ACT_SAMPLE, 32'hffff_ffff, 10'd1023, 16'h0000);
    send_item(sfp_pkg::ACT_SAMPLE, 32'h0, 10'd0, 16'h8001);
    send_item(sfp_pkg::ACT_FRAME_START, 32'h1234_5678, 10'd1023, 16'h0);
    // frame start that emits nothing, then frames closing on one sample
    configure(1'b0, 1'b1, 9'd1);
    send_item(sfp_pkg::ACT_FRAME_START, 32'hdead_beef, 10'd500, 16'h0);
    send_item(sfp_pkg::ACT_SAMPLE, 32'h0, 10'd0, 16'ha55a);
    send_item(sfp_pkg::ACT_SAMPLE, 32'h0, 10'd0, 16'h5aa5);
    // zero length counts as one
    configure(1'b0, 1'b0, 9'd0);
    send_item(sfp_pkg::ACT_SAMPLE, 32'h0, 10'd0, 16'h00ff);
    send_item(sfp_pkg::ACT_SAMPLE, 32'h0, 10'd0, 16'hff00);
    configure(1'b1, 1'b0, 9'd3);
    send_item(sfp_pkg::ACT_FRAME_START, 32'h8000_0001, 10'd512, 16'h0);
    send_item(sfp_pkg::ACT_SAMPLE, 32'h0, 10'd0, 16'h1234);
    send_item(sfp_pkg::ACT_SAMPLE, 32'h0, 10'd0, 16'h4321);
    // length lowered below the count and checksum switched on mid-frame
    configure(1'b0, 1'b1, 9'd1);
    send_item(sfp_pkg::ACT_SAMPLE, 32'h0, 10'd0, 16'hbeef);
    // length above the limit
    configure(1'b1, 1'b1, 9'd300);
    send_item(sfp_pkg::ACT_FRAME_START, 32'h0f0f_0f0f, 10'd1, 16'h0);
    send_item(sfp_pkg::ACT_SAMPLE, 32'h0, 10'd0, 16'h7fff);
    send_item(sfp_pkg::ACT_SAMPLE, 32'h0, 10'd0, 16'h8000);

    // receiver holds off while items keep coming, then a full drain pause
    configure(1'b1, 1'b1, 9'd4);
    quiet    = 1'b1;
    hold_len = 100;
    hold_req = 1'b1;
    run_items(24);
    wait_for_drain();
    quiet = 1'b0;
    run_items(12);

    foreach (spf_list[i]) run_phase(spf_list[i], 6);
    run_phase(9'd511, 262);
    run_phase(9'd16, 10);

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("sensor_frame_packer_tb: PASS");
    else
      $display("sensor_frame_packer_tb: FAIL");
    $finish;
  end

endmodule
